/* hw/rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the waypoint generator RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define SSW_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ssw assertion failed");

// next-cycle implication
`define SSW_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ssw assertion failed");

`endif

/* hw/rtl/ssw_pkg.sv */
// ----------------------------------------------------------------------------
// ssw_pkg
// Types and constants of the straight segment waypoint generator.
// ----------------------------------------------------------------------------
`default_nettype none

package ssw_pkg;

  typedef struct packed {
    logic signed [31:0] start_x;
    logic signed [31:0] start_y;
    logic signed [31:0] start_z;
    logic signed [31:0] end_x;
    logic signed [31:0] end_y;
    logic signed [31:0] end_z;
  } ssw_in_t;

  typedef struct packed {
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
    logic signed [15:0] heading_qz;
    logic signed [15:0] heading_qw;
    logic [6:0]         point_index;
    logic               last_point;
    logic               steps_clipped;
  } ssw_out_t;

  typedef struct packed {
    logic busy;
    logic done;
  } ssw_unit_sts_t;

  localparam int CFG_AW = 3;
  localparam logic REG_SPACING = 1'b0;

  localparam int SPACING_W = 23;
  localparam logic [SPACING_W-1:0] SPACING_RST = 23'd32768;
  localparam logic [SPACING_W-1:0] SPACING_MIN = 23'd3277;
  localparam logic [64:0] NEAR_LIMIT = 65'd4294;
  localparam logic [15:0] Q15_MAX = 16'd32767;

  // shared divider geometry
  localparam int DIV_LW = 32;
  localparam int DIV_DW = 33;
  localparam int DIV_CW = 6;

endpackage

`default_nettype wire

/* hw/rtl/ssw_div.sv */
// ----------------------------------------------------------------------------
// ssw_div
// Restoring bit-serial divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module ssw_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [ssw_pkg::DIV_DW-1:0]    hi_in,
  input  logic [ssw_pkg::DIV_LW-1:0]    lo_in,
  input  logic [ssw_pkg::DIV_DW-1:0]    den_in,
  input  logic [ssw_pkg::DIV_CW-1:0]    cnt_in,
  output logic [ssw_pkg::DIV_LW-1:0]    quot,
  output logic [ssw_pkg::DIV_DW-1:0]    rem,
  output ssw_pkg::ssw_unit_sts_t        sts
);
  import ssw_pkg::*;

  logic [DIV_DW-1:0] rem_r;
  logic [DIV_LW-1:0] lo_r;
  logic [DIV_DW-1:0] den_r;
  logic [DIV_CW-1:0] cnt_r;
  logic              busy_r;
  logic              done_r;
  logic [DIV_DW:0]   sh;
  logic              ge;

  assign sh = {rem_r, lo_r[DIV_LW-1]};
  assign ge = sh >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == DIV_CW'(1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= hi_in;
      lo_r  <= lo_in;
      den_r <= den_in;
      cnt_r <= cnt_in;
    end else if (busy_r) begin
      rem_r <= ge ? DIV_DW'(sh - {1'b0, den_r}) : sh[DIV_DW-1:0];
      lo_r  <= {lo_r[DIV_LW-2:0], ge};
      cnt_r <= cnt_r - DIV_CW'(1);
    end
  end

  assign quot = lo_r;
  assign rem  = rem_r;
  assign sts  = '{busy: busy_r, done: done_r};

endmodule

`default_nettype wire

/* hw/rtl/ssw_isqrt.sv */
// ----------------------------------------------------------------------------
// ssw_isqrt
// Digit-by-digit integer square root of a 64-bit value, with remainder.
// ----------------------------------------------------------------------------
`default_nettype none

module ssw_isqrt (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic [63:0]            v_in,
  output logic [31:0]            root,
  output logic [63:0]            rem,
  output ssw_pkg::ssw_unit_sts_t sts
);
  import ssw_pkg::*;

  logic [63:0] v_r;
  logic [63:0] res_r;
  logic [63:0] bit_r;
  logic        busy_r;
  logic        done_r;
  logic [63:0] trial;

  assign trial = res_r + bit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && bit_r[0]) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      v_r   <= v_in;
      res_r <= '0;
      bit_r <= 64'h4000_0000_0000_0000;
    end else if (busy_r) begin
      if (v_r >= trial) begin
        v_r   <= v_r - trial;
        res_r <= (res_r >> 1) + bit_r;
      end else begin
        res_r <= res_r >> 1;
      end
      bit_r <= bit_r >> 2;
    end
  end

  assign root = res_r[31:0];
  assign rem  = v_r;
  assign sts  = '{busy: busy_r, done: done_r};

endmodule

`default_nettype wire

/* hw/rtl/straight_segment_waypoints.sv */
// A segment shorter than 1 mm is dropped and gives no waypoints.
// Otherwise a segment takes two 31-step and three 32-step
// divisions and three 32-step square roots on shared serial units, a search
// and normalize phase, then one point per cycle while the output accepts.
// Throughput: one segment at a time; in_ready is high only between segments.
// Reset (synchronous, active low): idle, no result pending, spacing 0.5 m.
// ----------------------------------------------------------------------------
// straight_segment_waypoints
// Splits a segment into evenly spaced waypoints with a heading quaternion.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module straight_segment_waypoints #(
  parameter int MAX_STEPS = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  ssw_pkg::ssw_in_t              in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output ssw_pkg::ssw_out_t             out_data,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [ssw_pkg::CFG_AW-1:0]    cfg_paddr,
  input  logic [31:0]                   cfg_pwdata,
  output logic [31:0]                   cfg_prdata,
  output logic                          cfg_pready
);
  import ssw_pkg::*;

  localparam int SW = $clog2(MAX_STEPS + 2);
  localparam logic [SW-1:0] MAXS = SW'(MAX_STEPS);
  localparam logic [SW-1:0] LIM  = SW'(MAX_STEPS + 1);

  typedef enum logic [19:0] {
    S_IDLE  = 20'h00001,
    S_SQX   = 20'h00002,
    S_SQY   = 20'h00004,
    S_SUM   = 20'h00008,
    S_SRA   = 20'h00010,
    S_SRB   = 20'h00020,
    S_SRC   = 20'h00040,
    S_NORM  = 20'h00080,
    S_HSQX  = 20'h00100,
    S_HSQY  = 20'h00200,
    S_HSUM  = 20'h00400,
    S_HROOT = 20'h00800,
    S_HDIVW = 20'h01000,
    S_HDIVZ = 20'h02000,
    S_QW    = 20'h04000,
    S_QZ    = 20'h08000,
    S_DIVX  = 20'h10000,
    S_DIVY  = 20'h20000,
    S_DIVZ  = 20'h40000,
    S_EMIT  = 20'h80000
  } state_t;

  state_t state_r, state_nxt;

  logic [SPACING_W-1:0] spacing_r;
  logic [SPACING_W-1:0] sp;

  logic [31:0] sx_r, sy_r, sz_r;
  logic        ngx_r, ngy_r, ngz_r;
  logic [31:0] ax_r, ay_r, az_r;
  logic [31:0] hx_r, hy_r;
  logic [63:0] sq_r, sq2_r;
  logic [64:0] s_r;
  logic [SW-1:0] lo_r, hi_r;
  logic [29:0] t_r;
  logic [59:0] tt_r;
  logic [SW-1:0] steps_r;
  logic          clip_r;
  logic [31:0] r_r;
  logic [30:0] w2_r, z2_r;
  logic [15:0] qw_r, qz_r;
  logic [31:0] qdx_r, qdy_r, qdz_r;
  logic [SW:0] rdx_r, rdy_r, rdz_r;
  logic [31:0] accqx_r, accqy_r, accqz_r;
  logic [SW:0] accrx_r, accry_r, accrz_r;
  logic [SW-1:0] idx_r;
  logic          out_valid_r;
  ssw_out_t      out_r;

  // input differences
  logic signed [32:0] dx_w, dy_w, dz_w;
  assign dx_w = {in_data.end_x[31], in_data.end_x} - {in_data.start_x[31], in_data.start_x};
  assign dy_w = {in_data.end_y[31], in_data.end_y} - {in_data.start_y[31], in_data.start_y};
  assign dz_w = {in_data.end_z[31], in_data.end_z} - {in_data.start_z[31], in_data.start_z};

  // shared multiplier
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;
  assign mul_p = mul_a * mul_b;

  // search midpoint
  logic [SW:0]   midsum;
  logic [SW-1:0] mid;
  logic          cond;
  logic [SW-1:0] lo_n, hi_n;
  assign midsum = {1'b0, lo_r} + {1'b0, hi_r};
  assign mid    = midsum[SW:1];
  assign cond   = {5'b0, tt_r} >= s_r;
  assign lo_n   = cond ? lo_r : mid + SW'(1);
  assign hi_n   = cond ? mid : hi_r;

  logic [64:0] s_w;
  assign s_w = {1'b0, sq_r} + {1'b0, sq2_r};

  logic [31:0] m_w;
  assign m_w = (hx_r > hy_r) ? hx_r : hy_r;

  assign sp = (spacing_r < SPACING_MIN) ? SPACING_MIN : spacing_r;

  // shared units
  logic              div_start;
  logic [DIV_DW-1:0] div_hi, div_den;
  logic [DIV_LW-1:0] div_lo;
  logic [DIV_CW-1:0] div_cnt;
  logic [DIV_LW-1:0] div_q;
  logic [DIV_DW-1:0] div_rm;
  ssw_unit_sts_t     div_sts;

  logic          sq_start;
  logic [63:0]   sq_v;
  logic [31:0]   sq_root;
  logic [63:0]   sq_rem;
  ssw_unit_sts_t sq_sts;

  ssw_div u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (div_start),
    .hi_in  (div_hi),
    .lo_in  (div_lo),
    .den_in (div_den),
    .cnt_in (div_cnt),
    .quot   (div_q),
    .rem    (div_rm),
    .sts    (div_sts)
  );

  ssw_isqrt u_isqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sq_start),
    .v_in  (sq_v),
    .root  (sq_root),
    .rem   (sq_rem),
    .sts   (sq_sts)
  );

  // heading numerators
  logic [32:0] wn_w, zn_w;
  assign wn_w = ngx_r ? ({1'b0, sq_root} - {1'b0, hx_r}) : ({1'b0, sq_root} + {1'b0, hx_r});
  assign zn_w = ngx_r ? ({1'b0, r_r} + {1'b0, hx_r}) : ({1'b0, r_r} - {1'b0, hx_r});

  // Q1.15 rounding with saturation
  logic [16:0] up_w;
  logic [15:0] rnd_w;
  always_comb begin
    up_w  = sq_root[16:0] + 17'(sq_rem > {32'b0, sq_root});
    rnd_w = (up_w > {1'b0, Q15_MAX}) ? Q15_MAX : up_w[15:0];
  end

  function automatic logic [32+SW:0] lane_step(input logic [31:0] q, input logic [SW:0] r,
                                               input logic [31:0] qd, input logic [SW:0] rd,
                                               input logic [SW:0] st2);
    logic [SW+1:0] rs;
    logic          ge;
    logic [SW+1:0] rsub;
    logic [31:0]   qn;
    rs   = {1'b0, r} + {1'b0, rd};
    ge   = rs >= {1'b0, st2};
    rsub = ge ? rs - {1'b0, st2} : rs;
    qn   = q + qd + 32'(ge);
    return {qn, rsub[SW:0]};
  endfunction

  logic [SW:0]   st2;
  logic [32+SW:0] lx, ly, lz;
  logic [31:0]   px, py, pz;
  logic          fire;
  assign st2 = {steps_r, 1'b0};
  assign lx  = lane_step(accqx_r, accrx_r, qdx_r, rdx_r, st2);
  assign ly  = lane_step(accqy_r, accry_r, qdy_r, rdy_r, st2);
  assign lz  = lane_step(accqz_r, accrz_r, qdz_r, rdz_r, st2);
  assign px  = ngx_r ? sx_r - lx[32+SW:SW+1] : sx_r + lx[32+SW:SW+1];
  assign py  = ngy_r ? sy_r - ly[32+SW:SW+1] : sy_r + ly[32+SW:SW+1];
  assign pz  = ngz_r ? sz_r - lz[32+SW:SW+1] : sz_r + lz[32+SW:SW+1];
  assign fire = (state_r == S_EMIT) && (!out_valid_r || out_ready);

  // sequencer
  always_comb begin
    state_nxt = state_r;
    mul_a     = '0;
    mul_b     = '0;
    div_start = 1'b0;
    div_hi    = '0;
    div_lo    = '0;
    div_den   = '0;
    div_cnt   = '0;
    sq_start  = 1'b0;
    sq_v      = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_SQX;
      end
      S_SQX: begin
        mul_a = ax_r;
        mul_b = ax_r;
        state_nxt = S_SQY;
      end
      S_SQY: begin
        mul_a = ay_r;
        mul_b = ay_r;
        state_nxt = S_SUM;
      end
      S_SUM: begin
        if (!s_w[64] && s_w <= NEAR_LIMIT) state_nxt = S_IDLE;
        else if (s_w[64]) state_nxt = S_NORM;
        else state_nxt = S_SRA;
      end
      S_SRA: begin
        mul_a = 32'(mid);
        mul_b = 32'(sp);
        state_nxt = S_SRB;
      end
      S_SRB: begin
        mul_a = 32'(t_r);
        mul_b = 32'(t_r);
        state_nxt = S_SRC;
      end
      S_SRC: begin
        state_nxt = (lo_n == hi_n) ? S_NORM : S_SRA;
      end
      S_NORM: begin
        if (!m_w[31] && m_w[30]) state_nxt = S_HSQX;
      end
      S_HSQX: begin
        mul_a = hx_r;
        mul_b = hx_r;
        state_nxt = S_HSQY;
      end
      S_HSQY: begin
        mul_a = hy_r;
        mul_b = hy_r;
        state_nxt = S_HSUM;
      end
      S_HSUM: begin
        sq_start  = 1'b1;
        sq_v      = s_w[63:0];
        state_nxt = S_HROOT;
      end
      S_HROOT: begin
        if (sq_sts.done) begin
          div_start = 1'b1;
          div_hi    = {1'b0, wn_w[32:1]};
          div_lo    = {wn_w[0], 31'b0};
          div_den   = {sq_root, 1'b0};
          div_cnt   = DIV_CW'(31);
          state_nxt = S_HDIVW;
        end
      end
      S_HDIVW: begin
        if (div_sts.done) begin
          div_start = 1'b1;
          div_hi    = {1'b0, zn_w[32:1]};
          div_lo    = {zn_w[0], 31'b0};
          div_den   = {r_r, 1'b0};
          div_cnt   = DIV_CW'(31);
          state_nxt = S_HDIVZ;
        end
      end
      S_HDIVZ: begin
        if (div_sts.done) begin
          sq_start  = 1'b1;
          sq_v      = 64'(w2_r);
          state_nxt = S_QW;
        end
      end
      S_QW: begin
        if (sq_sts.done) begin
          sq_start  = 1'b1;
          sq_v      = 64'(z2_r);
          state_nxt = S_QZ;
        end
      end
      S_QZ: begin
        if (sq_sts.done) begin
          div_start = 1'b1;
          div_lo    = ax_r;
          div_den   = DIV_DW'(steps_r);
          div_cnt   = DIV_CW'(32);
          state_nxt = S_DIVX;
        end
      end
      S_DIVX: begin
        if (div_sts.done) begin
          div_start = 1'b1;
          div_lo    = ay_r;
          div_den   = DIV_DW'(steps_r);
          div_cnt   = DIV_CW'(32);
          state_nxt = S_DIVY;
        end
      end
      S_DIVY: begin
        if (div_sts.done) begin
          div_start = 1'b1;
          div_lo    = az_r;
          div_den   = DIV_DW'(steps_r);
          div_cnt   = DIV_CW'(32);
          state_nxt = S_DIVZ;
        end
      end
      S_DIVZ: begin
        if (div_sts.done) state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (fire && idx_r == steps_r) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      spacing_r   <= SPACING_RST;
    end else begin
      state_r <= state_nxt;
      if (fire) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr[2] == REG_SPACING) begin
        spacing_r <= cfg_pwdata[SPACING_W-1:0];
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          sx_r  <= in_data.start_x;
          sy_r  <= in_data.start_y;
          sz_r  <= in_data.start_z;
          ngx_r <= dx_w[32];
          ngy_r <= dy_w[32];
          ngz_r <= dz_w[32];
          ax_r  <= dx_w[32] ? 32'(-dx_w) : dx_w[31:0];
          ay_r  <= dy_w[32] ? 32'(-dy_w) : dy_w[31:0];
          az_r  <= dz_w[32] ? 32'(-dz_w) : dz_w[31:0];
          hx_r  <= dx_w[32] ? 32'(-dx_w) : dx_w[31:0];
          hy_r  <= dy_w[32] ? 32'(-dy_w) : dy_w[31:0];
        end
      end
      S_SQX, S_HSQX: sq_r <= mul_p;
      S_SQY, S_HSQY: sq2_r <= mul_p;
      S_SUM: begin
        s_r     <= s_w;
        lo_r    <= SW'(1);
        hi_r    <= LIM;
        steps_r <= MAXS;
        clip_r  <= 1'b1;
      end
      S_SRA: t_r <= mul_p[29:0];
      S_SRB: tt_r <= mul_p[59:0];
      S_SRC: begin
        lo_r <= lo_n;
        hi_r <= hi_n;
        if (lo_n == hi_n) begin
          steps_r <= (lo_n == LIM) ? MAXS : lo_n;
          clip_r  <= (lo_n == LIM);
        end
      end
      S_NORM: begin
        if (m_w[31]) begin
          hx_r <= hx_r >> 1;
          hy_r <= hy_r >> 1;
        end else if (!m_w[30]) begin
          hx_r <= hx_r << 1;
          hy_r <= hy_r << 1;
        end
      end
      S_HROOT: begin
        if (sq_sts.done) r_r <= sq_root;
      end
      S_HDIVW: begin
        if (div_sts.done) w2_r <= div_q[30:0];
      end
      S_HDIVZ: begin
        if (div_sts.done) z2_r <= div_q[30:0];
      end
      S_QW: begin
        if (sq_sts.done) qw_r <= rnd_w;
      end
      S_QZ: begin
        if (sq_sts.done) qz_r <= ngy_r ? 16'(-rnd_w) : rnd_w;
      end
      S_DIVX: begin
        if (div_sts.done) begin
          qdx_r <= div_q;
          rdx_r <= {div_rm[SW-1:0], 1'b0};
        end
      end
      S_DIVY: begin
        if (div_sts.done) begin
          qdy_r <= div_q;
          rdy_r <= {div_rm[SW-1:0], 1'b0};
        end
      end
      S_DIVZ: begin
        if (div_sts.done) begin
          qdz_r   <= div_q;
          rdz_r   <= {div_rm[SW-1:0], 1'b0};
          accqx_r <= '0;
          accqy_r <= '0;
          accqz_r <= '0;
          accrx_r <= {1'b0, steps_r};
          accry_r <= {1'b0, steps_r};
          accrz_r <= {1'b0, steps_r};
          idx_r   <= SW'(1);
        end
      end
      S_EMIT: begin
        if (fire) begin
          accqx_r <= lx[32+SW:SW+1];
          accqy_r <= ly[32+SW:SW+1];
          accqz_r <= lz[32+SW:SW+1];
          accrx_r <= lx[SW:0];
          accry_r <= ly[SW:0];
          accrz_r <= lz[SW:0];
          idx_r   <= idx_r + SW'(1);
          out_r.point_x       <= px;
          out_r.point_y       <= py;
          out_r.point_z       <= pz;
          out_r.heading_qz    <= qz_r;
          out_r.heading_qw    <= qw_r;
          out_r.point_index   <= 7'(idx_r);
          out_r.last_point    <= (idx_r == steps_r);
          out_r.steps_clipped <= clip_r;
        end
      end
      default: ;
    endcase
  end

  assign in_ready   = (state_r == S_IDLE);
  assign out_valid  = out_valid_r;
  assign out_data   = out_r;
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == REG_SPACING) ? 32'(spacing_r) : '0;

  `SSW_ASSERT_IMPLIES(a_emit_units_idle, clk, rst_n, state_r == S_EMIT, !div_sts.busy && !sq_sts.busy)
  `SSW_ASSERT_IMPLIES(a_search_bounds, clk, rst_n, state_r == S_SRA || state_r == S_SRB || state_r == S_SRC, lo_r < hi_r)
  `SSW_ASSERT_IMPLIES(a_index_range, clk, rst_n, state_r == S_EMIT, idx_r != '0 && idx_r <= steps_r)
  `SSW_ASSERT_NEXT(a_last_beat_ends, clk, rst_n, fire && idx_r == steps_r, out_valid && out_data.last_point)

endmodule

`default_nettype wire
